// ===== hdl/ifr_pkg.sv =====
// ---------------------------------------------------------------------------
// ifr_pkg: shared types and constants of the I-frame receiver
// Line byte codes, response control bytes, status codes and the token that
// travels from the byte classifier to the frame accounting stage.
// ---------------------------------------------------------------------------
package ifr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;

  localparam logic [7:0] RESP_RR0  = 8'h05;
  localparam logic [7:0] RESP_RR1  = 8'h85;
  localparam logic [7:0] RESP_REJ0 = 8'h01;
  localparam logic [7:0] RESP_REJ1 = 8'h81;

  localparam logic [7:0] ADDR_RESET  = 8'h03;
  localparam logic [3:0] LIMIT_RESET = 4'd10;

  // Register indexes on the configuration port
  localparam logic REG_ADDRESS = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  // Depth of the token queue between classifier and accounting stage
  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_DUP   = 2'd1,
    ST_REJ   = 2'd2,
    ST_ABORT = 2'd3
  } status_t;

  typedef enum logic {
    TK_DATA = 1'b0,
    TK_END  = 1'b1
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;       // unstuffed body byte
    logic       hdr_bad;    // address or BCC1 check failed
    logic       force_bad;  // frame already known bad at the closing flag
    logic       seq;        // bit 7 of the control byte
  } token_t;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  resp;
    logic        seq;
    logic [10:0] length;
  } result_t;

endpackage

// ===== hdl/iframe_receiver_with_ack.sv =====
// ---------------------------------------------------------------------------
// iframe_receiver_with_ack: HDLC-like I-frame receiver with stop-and-wait
// Takes raw line bytes, delimits frames on flags, checks header and BCC2,
// streams unstuffed payload one byte late and closes each frame with a
// status beat carrying the RR or REJ control byte to answer with.
//
//   channel  direction  beat contents
//   in_      slave      tdata[7:0] line byte
//   out_     master     tlast = status beat; tdata = payload, status, answer,
//                       sequence bit, payload length
//   cfg_     APB        0x0 expected address, 0x4 reject limit
//
// One line byte is taken per clock cycle while the token queue has room; each produces at most one beat.
// A byte passes the classifier, the token queue and the result register on its
// way to the output.
// Reset is synchronous and needs no clearing pass.
// A stalled output fills the four-entry token queue, after which in_tready
// falls; a stalled input leaves pending tokens draining.
// ---------------------------------------------------------------------------
module iframe_receiver_with_ack
  import ifr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] line_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                   // [17:10] response_control, [18] received_seq,
                                   // [29:19] payload_length, [31:30] zero
  output logic        out_tlast,   // is_frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] exp_addr_r;
  logic [3:0] rej_limit_r;
  logic       cfg_wr;
  logic       push, pop, q_empty, q_full;
  token_t     push_tok, head_tok;
  result_t    res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_LIMIT) ? {28'd0, rej_limit_r}
                                                  : {24'd0, exp_addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= ADDR_RESET;
      rej_limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ADDRESS) begin
        exp_addr_r <= cfg_pwdata[7:0];
      end else begin
        rej_limit_r <= cfg_pwdata[3:0];
      end
    end
  end

  ifr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_byte          (in_tdata),
    .expected_address (exp_addr_r),
    .q_full           (q_full),
    .push             (push),
    .push_tok         (push_tok)
  );

  ifr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .empty    (q_empty),
    .full     (q_full)
  );

  ifr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_tok     (head_tok),
    .q_empty      (q_empty),
    .pop          (pop),
    .reject_limit (rej_limit_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res)
  );

  assign out_tlast = res.is_end;
  assign out_tdata = {2'b00, res.length, res.seq, res.resp, res.status, res.payload_byte};

endmodule

// ===== hdl/ifr_front.sv =====
// ---------------------------------------------------------------------------
// ifr_front: line byte classifier
// Hunts for flags, parses and checks the header, removes byte stuffing and
// hands body bytes and closing flags on to the queue as tokens.
// ---------------------------------------------------------------------------
module ifr_front
  import ifr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [7:0] expected_address,
  input  logic       q_full,
  output logic       push,
  output token_t     push_tok
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_OPEN,
    PH_ADDR,
    PH_CTRL,
    PH_BODY
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       esc_r, esc_nxt;
  logic       hdr_bad_r, hdr_bad_nxt;
  logic       acc;
  logic       is_flag;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign is_flag  = (in_byte == FLAG_BYTE);

  always_comb begin
    phase_nxt   = phase_r;
    addr_nxt    = addr_r;
    ctrl_nxt    = ctrl_r;
    esc_nxt     = esc_r;
    hdr_bad_nxt = hdr_bad_r;
    push        = 1'b0;
    push_tok    = '{kind: TK_END, data: in_byte, hdr_bad: hdr_bad_r,
                    force_bad: 1'b1, seq: ctrl_r[7]};
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (is_flag) begin
            phase_nxt   = PH_OPEN;
            esc_nxt     = 1'b0;
            hdr_bad_nxt = 1'b0;
          end
        end
        PH_OPEN: begin
          if (!is_flag) begin
            addr_nxt  = in_byte;
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR, PH_CTRL: begin
          if (is_flag) begin
            // Flag inside the header: the frame is too short
            push        = 1'b1;
            phase_nxt   = PH_OPEN;
            esc_nxt     = 1'b0;
            hdr_bad_nxt = 1'b0;
          end else if (phase_r == PH_ADDR) begin
            ctrl_nxt  = in_byte;
            phase_nxt = PH_CTRL;
          end else begin
            hdr_bad_nxt = (in_byte != (addr_r ^ ctrl_r)) || (addr_r != expected_address);
            phase_nxt   = PH_BODY;
          end
        end
        PH_BODY: begin
          if (is_flag) begin
            push               = 1'b1;
            push_tok.force_bad = hdr_bad_r || esc_r;
            phase_nxt          = PH_OPEN;
            esc_nxt            = 1'b0;
            hdr_bad_nxt        = 1'b0;
          end else if (esc_r) begin
            push          = 1'b1;
            push_tok.kind = TK_DATA;
            push_tok.data = in_byte ^ ESC_MASK;
            esc_nxt       = 1'b0;
          end else if (in_byte == ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            push          = 1'b1;
            push_tok.kind = TK_DATA;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      addr_r    <= '0;
      ctrl_r    <= '0;
      esc_r     <= 1'b0;
      hdr_bad_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      addr_r    <= addr_nxt;
      ctrl_r    <= ctrl_nxt;
      esc_r     <= esc_nxt;
      hdr_bad_r <= hdr_bad_nxt;
    end
  end

  // Every closing flag reopens a frame, whatever came before it.
  a_flag_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_flag |=> phase_r == PH_OPEN)
    else $error("flag did not leave the classifier in the open phase");

  // A token is only produced for a beat actually taken from the line.
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> acc && (phase_r == PH_ADDR || phase_r == PH_CTRL || phase_r == PH_BODY))
    else $error("token pushed without an accepted body or header beat");

  // An escape is never carried across a frame boundary.
  a_esc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> phase_r == PH_BODY)
    else $error("escape pending outside the body");

endmodule

// ===== hdl/ifr_queue.sv =====
// ---------------------------------------------------------------------------
// ifr_queue: token queue
// Small first-in first-out store that lets classifier and accounting stage
// stall independently. Push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module ifr_queue
  import ifr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  input  logic   pop,
  output token_t head_tok,
  output logic   empty,
  output logic   full
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  token_t        mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(QDEPTH));
  assign head_tok = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("token pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH))
    else $error("queue fill count beyond its depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("token popped from an empty queue");

endmodule

// ===== hdl/ifr_back.sv =====
// ---------------------------------------------------------------------------
// ifr_back: frame accounting stage
// Delays body bytes by one to hold back BCC2, keeps the running XOR and the
// payload count, and at the closing flag gives the verdict, the answer and
// the sequence and reject bookkeeping. Results leave through a register.
// ---------------------------------------------------------------------------
module ifr_back
  import ifr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  token_t     head_tok,
  input  logic       q_empty,
  output logic       pop,
  input  logic [3:0] reject_limit,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned LW = (CW > 11) ? CW : 11;

  logic [7:0]    held_r, held_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          exp_seq_r, exp_seq_nxt;
  logic [3:0]    rej_run_r, rej_run_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt;
  logic          good;
  logic [LW-1:0] count_ext;

  assign pop       = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign count_ext = LW'(count_r);
  assign good      = !head_tok.force_bad && !head_tok.hdr_bad && !ovf_r &&
                     held_valid_r && (xor_r == '0);

  always_comb begin
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    xor_nxt        = xor_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    exp_seq_nxt    = exp_seq_r;
    rej_run_nxt    = rej_run_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (pop) begin
      case (head_tok.kind)
        TK_DATA: begin
          if (held_valid_r && !head_tok.hdr_bad && !ovf_r) begin
            if (count_r >= CW'(MAX_PAYLOAD)) begin
              ovf_nxt = 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
              res_nxt       = '{is_end: 1'b0, payload_byte: held_r, status: ST_NEW,
                                resp: 8'h00, seq: 1'b0, length: 11'd0};
              count_nxt     = count_r + 1'b1;
            end
          end
          held_nxt       = head_tok.data;
          held_valid_nxt = 1'b1;
          xor_nxt        = xor_r ^ head_tok.data;
        end
        TK_END: begin
          out_valid_nxt        = 1'b1;
          res_nxt.is_end       = 1'b1;
          res_nxt.payload_byte = 8'h00;
          res_nxt.length       = count_ext[10:0];
          if (good) begin
            res_nxt.seq = head_tok.seq;
            rej_run_nxt = '0;
            if (head_tok.seq == exp_seq_r) begin
              res_nxt.status = ST_NEW;
              exp_seq_nxt    = !exp_seq_r;
            end else begin
              res_nxt.status = ST_DUP;
            end
            res_nxt.resp = exp_seq_nxt ? RESP_RR1 : RESP_RR0;
          end else begin
            res_nxt.seq  = 1'b0;
            res_nxt.resp = exp_seq_r ? RESP_REJ1 : RESP_REJ0;
            if (rej_run_r >= reject_limit) begin
              res_nxt.status = ST_ABORT;
              rej_run_nxt    = '0;
            end else begin
              res_nxt.status = ST_REJ;
              rej_run_nxt    = rej_run_r + 1'b1;
            end
          end
          held_valid_nxt = 1'b0;
          held_nxt       = 8'h00;
          xor_nxt        = '0;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
        end
        default: begin
          ovf_nxt = ovf_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    held_r <= held_nxt;
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      xor_r        <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      exp_seq_r    <= 1'b0;
      rej_run_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      xor_r        <= xor_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      exp_seq_r    <= exp_seq_nxt;
      rej_run_r    <= rej_run_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // A status beat always leaves the accounting for a fresh frame.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_tok.kind == TK_END |=> !held_valid_r && count_r == '0 && !ovf_r)
    else $error("frame state not cleared after a status beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_PAYLOAD))
    else $error("payload count beyond the maximum");

  // A waiting result is never overwritten before it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_r))
    else $error("pending result changed while stalled");

endmodule

// ===== test/iframe_receiver_with_ack_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iframe_receiver_with_ack_checker: scoreboard for the I-frame receiver
// Watches accepted line bytes, register writes and result beats. It keeps an
// independent model of the frame receiver, queues the beats each line byte
// should cause, and checks every result beat against the oldest of them.
// ---------------------------------------------------------------------------
module iframe_receiver_with_ack_checker
  import ifr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          pending,
  output int          failures
);

  typedef enum logic [2:0] {
    LN_HUNT,
    LN_OPEN,
    LN_ADDR,
    LN_CTRL,
    LN_BODY
  } line_phase_t;

  line_phase_t phase;
  logic [7:0]  hdr_addr;
  logic [7:0]  hdr_ctrl;
  logic [7:0]  held_byte;
  logic [7:0]  body_xor;
  logic [7:0]  own_addr;
  logic        esc_seen;
  logic        held_ok;
  logic        frame_bad;
  logic        want_seq;
  logic [10:0] payload_count;
  logic [3:0]  reject_run;
  logic [3:0]  reject_limit;
  result_t     expected_beats[$];
  int          mismatch_count = 0;

  function automatic void clear_frame();
    esc_seen      = 1'b0;
    held_byte     = 8'h00;
    held_ok       = 1'b0;
    body_xor      = 8'h00;
    payload_count = '0;
    frame_bad     = 1'b0;
  endfunction

  // Closing flag: status beat, then the flag also opens the next frame.
  function automatic void close_frame(input logic good);
    result_t r;
    r        = '0;
    r.is_end = 1'b1;
    if (good) begin
      r.seq = hdr_ctrl[7];
      if (r.seq == want_seq) begin
        r.status = ST_NEW;
        want_seq = ~want_seq;
      end else begin
        r.status = ST_DUP;
      end
      r.resp     = want_seq ? RESP_RR1 : RESP_RR0;
      reject_run = '0;
    end else begin
      r.resp = want_seq ? RESP_REJ1 : RESP_REJ0;
      if (reject_run >= reject_limit) begin
        r.status   = ST_ABORT;
        reject_run = '0;
      end else begin
        r.status   = ST_REJ;
        reject_run = reject_run + 4'd1;
      end
    end
    r.length = payload_count;
    expected_beats.push_back(r);
    phase = LN_OPEN;
    clear_frame();
  endfunction

  function automatic void take_line_byte(input logic [7:0] b);
    logic [7:0] c;
    result_t    r;
    case (phase)
      LN_HUNT: begin
        if (b == FLAG_BYTE) begin
          phase = LN_OPEN;
          clear_frame();
        end
      end
      LN_OPEN: begin
        if (b != FLAG_BYTE) begin
          hdr_addr = b;
          phase    = LN_ADDR;
        end
      end
      LN_ADDR: begin
        if (b == FLAG_BYTE) begin
          close_frame(1'b0);
        end else begin
          hdr_ctrl = b;
          phase    = LN_CTRL;
        end
      end
      LN_CTRL: begin
        if (b == FLAG_BYTE) begin
          close_frame(1'b0);
        end else begin
          if (b != (hdr_addr ^ hdr_ctrl) || hdr_addr != own_addr) frame_bad = 1'b1;
          phase = LN_BODY;
        end
      end
      LN_BODY: begin
        if (b == FLAG_BYTE) begin
          close_frame(!frame_bad && !esc_seen && held_ok && body_xor == 8'h00);
        end else if (!esc_seen && b == ESC_BYTE) begin
          esc_seen = 1'b1;
        end else begin
          c        = esc_seen ? (b ^ ESC_MASK) : b;
          esc_seen = 1'b0;
          // Payload goes out one byte late, so the final byte (BCC2) never does.
          if (held_ok && !frame_bad) begin
            if (payload_count >= MAX_PAYLOAD) begin
              frame_bad = 1'b1;
            end else begin
              r              = '0;
              r.payload_byte = held_byte;
              expected_beats.push_back(r);
              payload_count  = payload_count + 11'd1;
            end
          end
          held_byte = c;
          held_ok   = 1'b1;
          body_xor  = body_xor ^ c;
        end
      end
      default: phase = LN_HUNT;
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected end=%0b byte=%02h status=%0d resp=%02h seq=%0b len=%0d",
               $time, what, want.is_end, want.payload_byte, want.status, want.resp,
               want.seq, want.length);
      $display("%0t: %s:      got end=%0b byte=%02h status=%0d resp=%02h seq=%0b len=%0d",
               $time, what, got.is_end, got.payload_byte, got.status, got.resp,
               got.seq, got.length);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      own_addr     = ADDR_RESET;
      reject_limit = LIMIT_RESET;
      phase        = LN_HUNT;
      hdr_addr     = 8'h00;
      hdr_ctrl     = 8'h00;
      want_seq     = 1'b0;
      reject_run   = '0;
      clear_frame();
      expected_beats.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.is_end       = out_tlast;
        got.payload_byte = out_tdata[7:0];
        got.status       = status_t'(out_tdata[9:8]);
        got.resp         = out_tdata[17:10];
        got.seq          = out_tdata[18];
        got.length       = out_tdata[29:19];
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing expected", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want || out_tdata[31:30] !== 2'b00)
            report_mismatch("result beat", want, got);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_ADDRESS) own_addr = cfg_pwdata[7:0];
        else reject_limit = cfg_pwdata[3:0];
      end
      if (in_tvalid && in_tready) take_line_byte(in_tdata);
    end
    pending  <= expected_beats.size();
    failures <= mismatch_count;
  end

endmodule

// ===== test/iframe_receiver_with_ack_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iframe_receiver_with_ack_tb: testbench top for the I-frame receiver
// Builds line byte streams of good, duplicate and damaged frames plus noise,
// runs them through several address and reject-limit settings with random
// gaps on both channels, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module iframe_receiver_with_ack_tb;
  import ifr_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 1024;

  typedef enum int {
    FR_GOOD,
    FR_BAD_ADDR,
    FR_BAD_BCC1,
    FR_BAD_BCC2,
    FR_SHORT,
    FR_DANGLING_ESC,
    FR_NOISE
  } frame_kind_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;    // [7:0] payload, [9:8] status, [17:10] answer,
                             // [18] seq, [29:19] length, [31:30] zero
  logic        out_tlast;    // status beat
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = 3'd0;
  logic [31:0] cfg_pwdata  = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          pending;
  int          failures;

  logic [7:0]  line_q[$];
  logic [7:0]  cur_addr = ADDR_RESET;
  int          sent     = 0;
  bit          tx_calm  = 1'b0;

  iframe_receiver_with_ack #(.MAX_PAYLOAD(MAX_PAYLOAD)) DUT (.*);

  iframe_receiver_with_ack_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .pending, .failures
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[iframe_receiver_with_ack] ERROR");
    $finish;
  end

  // Result side: random stall before each beat, with calm stretches.
  initial begin : result_sink
    int stall;
    int beats;
    bit calm;
    beats = 0;
    calm  = 1'b0;
    forever begin
      if (beats % 80 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sent % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Hold the line until every expected beat has come out.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_line();
    while (line_q.size() != 0) begin
      send_byte(line_q.pop_front());
      if ($urandom_range(0, 299) == 0) hold_until_drained();
    end
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] any_but_flag();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == FLAG_BYTE);
    return v;
  endfunction

  function automatic logic [7:0] payload_value();
    case ($urandom_range(0, 7))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Bytes that look like flag or escape must be escaped; others sometimes are.
  function automatic void stuff_byte(input logic [7:0] v);
    if (v == FLAG_BYTE || v == ESC_BYTE ||
        ($urandom_range(0, 15) == 0 && (v ^ ESC_MASK) != FLAG_BYTE)) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(v ^ ESC_MASK);
    end else begin
      line_q.push_back(v);
    end
  endfunction

  // Appends one frame body and its closing flag; the previous flag opens it.
  function automatic void build_frame(input frame_kind_t kind, input int plen);
    logic [7:0] a;
    logic [7:0] c;
    logic [7:0] bcc;
    logic [7:0] v;
    int         n;
    a = cur_addr;
    if (kind == FR_BAD_ADDR) begin
      do a = any_but_flag(); while (a == cur_addr);
    end
    do c = any_but_flag(); while ((a ^ c) == FLAG_BYTE);
    bcc = a ^ c;
    if (kind == FR_BAD_BCC1) begin
      do bcc = a ^ c ^ 8'($urandom_range(1, 255)); while (bcc == FLAG_BYTE);
    end
    case (kind)
      FR_SHORT: begin
        n = $urandom_range(1, 3);
        repeat (n) line_q.push_back(any_but_flag());
      end
      FR_NOISE: begin
        n = $urandom_range(1, 10);
        repeat (n) line_q.push_back(($urandom_range(0, 3) == 0) ? FLAG_BYTE
                                                                : payload_value());
      end
      default: begin
        line_q.push_back(a);
        line_q.push_back(c);
        line_q.push_back(bcc);
        bcc = 8'h00;
        for (int i = 0; i < plen; i++) begin
          v   = payload_value();
          bcc = bcc ^ v;
          stuff_byte(v);
        end
        if (kind == FR_DANGLING_ESC) begin
          line_q.push_back(ESC_BYTE);
        end else begin
          if (kind == FR_BAD_BCC2) bcc = bcc ^ 8'($urandom_range(1, 255));
          stuff_byte(bcc);
        end
      end
    endcase
    line_q.push_back(FLAG_BYTE);
    if ($urandom_range(0, 7) == 0) line_q.push_back(FLAG_BYTE);
  endfunction

  initial begin : stimulus
    logic [7:0]  addr;
    logic [3:0]  limit;
    int          bad_pct;
    int          phase_end;
    int          plen;
    frame_kind_t kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes before the first flag, an idle flag pair, a good frame whose
    // payload needs escaping, a duplicate with empty payload, a frame cut
    // short after the address, and a frame ending on a dangling escape.
    line_q = '{8'h00, 8'hFF, FLAG_BYTE, FLAG_BYTE,
               ADDR_RESET, 8'h00, ADDR_RESET, ESC_BYTE, 8'h5E, ESC_BYTE, 8'h5D,
               8'h03, FLAG_BYTE,
               ADDR_RESET, 8'h00, ADDR_RESET, 8'h00, FLAG_BYTE,
               ADDR_RESET, FLAG_BYTE,
               ADDR_RESET, 8'h80, ADDR_RESET ^ 8'h80, ESC_BYTE, FLAG_BYTE};
    send_line();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin addr = 8'h03; limit = 4'd2; bad_pct = 30; end
        1: begin addr = 8'h00; limit = 4'd1; bad_pct = 50; end
        2: begin addr = 8'hFF; limit = 4'd15; bad_pct = 90; end
        3: begin addr = any_but_flag(); limit = 4'($urandom_range(1, 15)); bad_pct = 40; end
        default: begin addr = 8'hA5; limit = 4'd6; bad_pct = 15; end
      endcase
      // A flag or escape byte still in the pipe causes no beat, so allow for it.
      hold_until_drained();
      repeat (12) @(posedge clk);
      apb_write(REG_ADDRESS, {24'd0, addr});
      apb_write(REG_LIMIT, {28'd0, limit});
      cur_addr = addr;

      phase_end = sent + 300;
      while (sent < phase_end) begin
        if ($urandom_range(0, 99) < bad_pct) kind = frame_kind_t'($urandom_range(1, 6));
        else kind = FR_GOOD;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        build_frame(kind, plen);
        send_line();
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("[iframe_receiver_with_ack] OK");
    end else begin
      $display("[iframe_receiver_with_ack] ERROR");
    end
    $finish;
  end

endmodule
